// ----- src/gcmg_pkg.sv -----
// Shared types and codes for the GCM GHASH tag unit.
package gcmg_pkg;

   localparam int BLOCK_BITS  = 128;
   localparam int BLOCK_BYTES = 16;
   localparam int WORD_BITS   = 64;
   localparam int COUNT_BITS  = 61;
   localparam int NBYTES_BITS = 5;
   localparam int FUNC_BITS   = 3;
   localparam int CSR_ADDR_BITS = 1;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_BITS = 264;
   localparam int RSP_DATA_BITS = 136;

   // Reduction polynomial x^128 + x^7 + x^2 + x + 1 (0xE1 in GCM bit order).
   localparam logic [7:0] REDUCE_TAPS = 8'h87;

   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR       = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_ABSORB_AAD  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_ABSORB_CT   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_FINISH      = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_VERIFY      = 3'd4;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_HASH_KEY_HIGH = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HASH_KEY_LOW  = 1'd1;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [WORD_BITS-1:0]   block_high;
      logic [WORD_BITS-1:0]   block_low;
      logic [NBYTES_BITS-1:0] valid_bytes;
      logic [WORD_BITS-1:0]   expect_high;
      logic [WORD_BITS-1:0]   expect_low;
   } req_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] tag_high;
      logic [WORD_BITS-1:0] tag_low;
      logic                 tag_match;
   } rsp_item_type;

   typedef struct packed {
      logic                     we;
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0]     wdata;
   } csr_write_type;

endpackage

// ----- src/gcmg_gf128_mul.sv -----
// GF(2^128) multiplier in GCM bit order: carry-less product and two-step fold.
module gcmg_gf128_mul (
   input  logic [gcmg_pkg::BLOCK_BITS-1:0] x,
   input  logic [gcmg_pkg::BLOCK_BITS-1:0] h,
   output logic [gcmg_pkg::BLOCK_BITS-1:0] z
);
   import gcmg_pkg::*;

   logic [BLOCK_BITS-1:0]   a;
   logic [BLOCK_BITS-1:0]   b;
   logic [2*BLOCK_BITS-2:0] prod;
   logic [BLOCK_BITS-2:0]   hi;
   logic [BLOCK_BITS+6:0]   fold1;
   logic [6:0]              over;
   logic [13:0]             fold2;
   logic [BLOCK_BITS-1:0]   r;

   // GCM puts the x^0 coefficient in the MSB, so reverse into normal order.
   always_comb begin
      for (int i = 0; i < BLOCK_BITS; i++) begin
         a[i] = x[BLOCK_BITS-1-i];
         b[i] = h[BLOCK_BITS-1-i];
      end
   end

   always_comb begin
      prod = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         for (int j = 0; j < BLOCK_BITS; j++) begin
            prod[i+j] = prod[i+j] ^ (a[i] & b[j]);
         end
      end
   end

   // x^128 == x^7 + x^2 + x + 1; the first fold leaves at most six bits over.
   always_comb begin
      hi    = prod[2*BLOCK_BITS-2:BLOCK_BITS];
      fold1 = '0;
      for (int t = 0; t < 8; t++) begin
         if (REDUCE_TAPS[t]) begin
            fold1 = fold1 ^ ((BLOCK_BITS+7)'(hi) << t);
         end
      end
      over  = fold1[BLOCK_BITS+6:BLOCK_BITS];
      fold2 = '0;
      for (int t = 0; t < 8; t++) begin
         if (REDUCE_TAPS[t]) begin
            fold2 = fold2 ^ (14'(over) << t);
         end
      end
      r = prod[BLOCK_BITS-1:0] ^ fold1[BLOCK_BITS-1:0]
          ^ {{(BLOCK_BITS-14){1'b0}}, fold2};
      for (int i = 0; i < BLOCK_BITS; i++) begin
         z[i] = r[BLOCK_BITS-1-i];
      end
   end

endmodule

// ----- src/gcmg_core.sv -----
// GHASH state, hash key registers and the per-beat update logic.
module gcmg_core (
   input  logic                    clock,
   input  logic                    reset,
   input  gcmg_pkg::csr_write_type csr,
   input  gcmg_pkg::req_item_type  item,
   input  logic                    step_en,
   output gcmg_pkg::rsp_item_type  result
);
   import gcmg_pkg::*;

   logic [WORD_BITS-1:0]  key_high_ff, key_high_in;
   logic [WORD_BITS-1:0]  key_low_ff, key_low_in;
   logic [BLOCK_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] aad_count_ff, aad_count_in;
   logic [COUNT_BITS-1:0] ct_count_ff, ct_count_in;

   logic [NBYTES_BITS-1:0] n_sat;
   logic [BLOCK_BITS-1:0]  byte_mask;
   logic [BLOCK_BITS-1:0]  block;
   logic [BLOCK_BITS-1:0]  len_block;
   logic [BLOCK_BITS-1:0]  mul_in;
   logic [BLOCK_BITS-1:0]  mul_out;
   logic [BLOCK_BITS-1:0]  tag;
   logic                   is_absorb;

   always_comb begin
      n_sat = (item.valid_bytes > NBYTES_BITS'(BLOCK_BYTES)) ?
              NBYTES_BITS'(BLOCK_BYTES) : item.valid_bytes;
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         byte_mask[BLOCK_BITS-1-8*b -: 8] = (NBYTES_BITS'(b) < n_sat) ? 8'hFF : 8'h00;
      end
      block     = {item.block_high, item.block_low};
      len_block = {aad_count_ff, 3'b000, ct_count_ff, 3'b000};
      is_absorb = (item.func == FUNC_ABSORB_AAD || item.func == FUNC_ABSORB_CT)
                  && (n_sat != '0);
      mul_in    = is_absorb ? (acc_ff ^ (block & byte_mask)) : (acc_ff ^ len_block);
      tag       = mul_out ^ block;
   end

   gcmg_gf128_mul u_mul (
      .x (mul_in),
      .h ({key_high_ff, key_low_ff}),
      .z (mul_out)
   );

   always_comb begin
      acc_in           = acc_ff;
      aad_count_in     = aad_count_ff;
      ct_count_in      = ct_count_ff;
      result.tag_high  = acc_ff[BLOCK_BITS-1:WORD_BITS];
      result.tag_low   = acc_ff[WORD_BITS-1:0];
      result.tag_match = 1'b0;
      case (item.func)
         FUNC_CLEAR: begin
            acc_in       = '0;
            aad_count_in = '0;
            ct_count_in  = '0;
            result.tag_high = '0;
            result.tag_low  = '0;
         end
         FUNC_ABSORB_AAD, FUNC_ABSORB_CT: begin
            if (is_absorb) begin
               acc_in          = mul_out;
               result.tag_high = mul_out[BLOCK_BITS-1:WORD_BITS];
               result.tag_low  = mul_out[WORD_BITS-1:0];
               if (item.func == FUNC_ABSORB_AAD) begin
                  aad_count_in = aad_count_ff + COUNT_BITS'(n_sat);
               end else begin
                  ct_count_in = ct_count_ff + COUNT_BITS'(n_sat);
               end
            end
         end
         FUNC_FINISH, FUNC_VERIFY: begin
            acc_in          = '0;
            aad_count_in    = '0;
            ct_count_in     = '0;
            result.tag_high = tag[BLOCK_BITS-1:WORD_BITS];
            result.tag_low  = tag[WORD_BITS-1:0];
            if (item.func == FUNC_VERIFY) begin
               result.tag_match = (tag == {item.expect_high, item.expect_low});
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr.we) begin
         case (csr.addr)
            CSR_HASH_KEY_HIGH: key_high_in = csr.wdata;
            CSR_HASH_KEY_LOW:  key_low_in  = csr.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         acc_ff       <= '0;
         aad_count_ff <= '0;
         ct_count_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         if (step_en) begin
            acc_ff       <= acc_in;
            aad_count_ff <= aad_count_in;
            ct_count_ff  <= ct_count_in;
         end
      end
   end

endmodule

// ----- src/gcm_ghash_tag_unit.sv -----
// Top level of the GCM GHASH tag unit: input register, core and result register.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  req_tuser = func, req_tdata = block, counts
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata = tag and match flag
//   csr_     in         csr_we (no wait)       csr_addr = register index, csr_wdata
//
// One beat is accepted per cycle while the result side is not stalled; a result
// passes through the input register and then the result register.
// The rate is set by the combinational GF(2^128) multiply against the stored key.
// Reset is synchronous and active high; it clears the key, accumulator and counts.
// A stalled result holds in the result register while the input register still
// takes one more beat, so the request side stalls only after two beats back up.
module gcm_ghash_tag_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: block_high[63:0], block_low[127:64],
   // valid_bytes[132:128], expect_high[196:133], expect_low[260:197], zero pad.
   input  logic [gcmg_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // Fields from bit 0 up: func[2:0].
   input  logic [gcmg_pkg::FUNC_BITS-1:0]         req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: tag_high[63:0], tag_low[127:64], tag_match[128], zero pad.
   output logic [gcmg_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                   csr_we,
   input  logic [gcmg_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [gcmg_pkg::WORD_BITS-1:0]         csr_wdata
);
   import gcmg_pkg::*;

   req_item_type  item_ff, item_in;
   logic          in_valid_ff, in_valid_in;
   rsp_item_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   csr_write_type csr;
   rsp_item_type  result;
   logic          advance;
   logic          req_fire;

   // The input stage moves whenever the result register is empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      item_in.func        = req_tuser;
      item_in.block_high  = req_tdata[63:0];
      item_in.block_low   = req_tdata[127:64];
      item_in.valid_bytes = req_tdata[132:128];
      item_in.expect_high = req_tdata[196:133];
      item_in.expect_low  = req_tdata[260:197];
      in_valid_in         = req_fire || (in_valid_ff && !advance);
      rsp_valid_in        = (in_valid_ff && advance) || (rsp_valid_ff && !rsp_tready);
      rsp_in              = result;
   end

   assign csr.we    = csr_we;
   assign csr.addr  = csr_addr;
   assign csr.wdata = csr_wdata;

   // The state advances exactly when the held beat moves into the result register.
   gcmg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .item    (item_ff),
      .step_en (in_valid_ff && advance),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (in_valid_ff && advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.tag_match, rsp_ff.tag_low, rsp_ff.tag_high};

endmodule

// ----- src/gcmg_checker.sv -----
// Port-level checks for the GCM GHASH tag unit, bound to the top level.
module gcmg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [gcmg_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import gcmg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled with an empty result register");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:BLOCK_BITS+1] == '0)
      else $error("result pad bits not zero");

endmodule

bind gcm_ghash_tag_unit gcmg_checker u_gcmg_checker (.*);
